@@ rtl/smf_pkg.sv @@
package smf_pkg;

    localparam logic [31:0] MTRK_MAGIC      = 32'h4D54_726B;
    localparam logic [30:0] TICK_MAX        = 31'h7FFF_FFFF;
    localparam logic [23:0] DEFAULT_TEMPO   = 24'd500000;
    localparam logic [7:0]  META_TEMPO      = 8'h51;
    localparam logic [7:0]  META_EOT        = 8'h2F;
    localparam logic [7:0]  STAT_META       = 8'hFF;
    localparam logic [7:0]  STAT_SYSEX      = 8'hF0;
    localparam logic [7:0]  STAT_SYSEX_ESC  = 8'hF7;
    localparam logic [3:0]  HI_NOTE_OFF     = 4'h8;
    localparam logic [3:0]  HI_NOTE_ON      = 4'h9;
    localparam logic [3:0]  HI_PROG_CHANGE  = 4'hC;
    localparam logic [3:0]  HI_CHAN_PRESS   = 4'hD;
    localparam logic [3:0]  HI_PITCH_BEND   = 4'hE;

    typedef enum logic [2:0] {
        KIND_NOTE_ON   = 3'd0,
        KIND_NOTE_OFF  = 3'd1,
        KIND_TEMPO     = 3'd2,
        KIND_TRACK_END = 3'd3,
        KIND_ERROR     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_BAD_MAGIC  = 3'd0,
        ERR_TRUNCATED  = 3'd1,
        ERR_LONG_VLQ   = 3'd2,
        ERR_NO_RUNNING = 3'd3,
        ERR_BAD_STATUS = 3'd4
    } t_err_code;

    typedef enum logic [3:0] {
        PH_MAGIC     = 4'd0,
        PH_LEN       = 4'd1,
        PH_DELTA     = 4'd2,
        PH_STATUS    = 4'd3,
        PH_DATA1     = 4'd4,
        PH_DATA2     = 4'd5,
        PH_META_TYPE = 4'd6,
        PH_META_LEN  = 4'd7,
        PH_SYX_LEN   = 4'd8,
        PH_PAYLOAD   = 4'd9,
        PH_SKIP_END  = 4'd10
    } t_phase;

    typedef struct packed {
        t_kind     kind;
        logic [30:0] abs_tick;
        logic [7:0]  note_number;
        logic [7:0]  velocity;
        logic [23:0] tempo_us;
        t_err_code error_code;
        logic        last_of_run;
    } t_result;

    // results caused by one input beat: num is 0, 1 or 2
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

@@ rtl/smf_track_event_parser.sv @@
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_data_byte
// out      output     o_out_valid / i_out_stall   o_kind, o_abs_tick, o_note_number,
//                                                 o_velocity, o_tempo_us, o_error_code,
//                                                 o_last_of_run
// One byte per cycle while o_in_stall is low; the decoder updates its state in the cycle the beat is accepted.
// Results land in a 4-entry output queue; the first is visible the next cycle.
// A byte can cause two results (event plus track end), so input stalls while the
// queue has fewer than two free slots.
// Synchronous active-low reset; ready for the chunk magic right after reset.
module smf_track_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [30:0] o_abs_tick,
    output logic [7:0]  o_note_number,
    output logic [7:0]  o_velocity,
    output logic [23:0] o_tempo_us,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run
);
    import smf_pkg::*;

    t_dec_out   dec;
    logic       in_accept;
    logic       pop;
    t_result    head;
    t_result    r_q [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count,  n_count;

    assign o_in_stall = (r_count > 3'd2);
    assign in_accept  = i_in_valid && !o_in_stall;

    smf_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .o_dec       (dec)
    );

    assign head        = r_q[r_rd_ptr];
    assign o_out_valid = (r_count != 3'd0);
    assign pop         = o_out_valid && !i_out_stall;

    assign o_kind        = head.kind;
    assign o_abs_tick    = head.abs_tick;
    assign o_note_number = head.note_number;
    assign o_velocity    = head.velocity;
    assign o_tempo_us    = head.tempo_us;
    assign o_error_code  = head.error_code;
    assign o_last_of_run = head.last_of_run;

    always_comb begin
        n_wr_ptr = r_wr_ptr + dec.num;
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {1'b0, dec.num} - {2'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (dec.num != 2'd0) begin
            r_q[r_wr_ptr] <= dec.res0;
        end
        if (dec.num == 2'd2) begin
            r_q[r_wr_ptr + 2'd1] <= dec.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output queue overflow");

    a_room_for_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec.num != 2'd0) |-> (r_count <= 3'd2))
        else $error("results pushed without two free slots");

    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dec.num != 2'd0 && dec.res0.kind == KIND_ERROR) |=> (dec.num == 2'd0))
        else $error("result pushed after an error beat");

endmodule

@@ rtl/smf_decode.sv @@
module smf_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    output smf_pkg::t_dec_out o_dec
);
    import smf_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [1:0]  r_hdr_cnt,    n_hdr_cnt;
    logic [31:0] r_chunk_rem,  n_chunk_rem;
    logic [27:0] r_vlq_val,    n_vlq_val;
    logic [1:0]  r_vlq_cnt,    n_vlq_cnt;
    logic [30:0] r_tick,       n_tick;
    logic [7:0]  r_running,    n_running;
    logic [7:0]  r_cur_status, n_cur_status;
    logic [7:0]  r_meta_kind,  n_meta_kind;
    logic [27:0] r_pay_rem,    n_pay_rem;
    logic [7:0]  r_first_data, n_first_data;
    logic [23:0] r_tempo,      n_tempo;
    logic        r_err,        n_err;

    logic        step;
    logic [27:0] vlq_next;
    logic        vlq_long;
    logic [31:0] tick_sum;
    logic [31:0] rem_dec;
    logic [27:0] pay_dec;
    logic [31:0] rem_shift;
    logic        take_data;
    logic [7:0]  data_status;
    logic        evt;
    t_kind       evt_kind;
    logic [7:0]  evt_note;
    logic [7:0]  evt_vel;
    logic [23:0] evt_tempo;
    logic        trk_end;
    logic        fail;
    t_err_code   fail_code;

    assign step      = i_accept && !r_err;
    assign vlq_next  = {r_vlq_val[20:0], i_data_byte[6:0]};
    assign vlq_long  = i_data_byte[7] && (r_vlq_cnt == 2'd3);
    assign tick_sum  = {1'b0, r_tick} + {4'b0, vlq_next};
    assign rem_dec   = r_chunk_rem - 32'd1;
    assign pay_dec   = r_pay_rem - 28'd1;
    assign rem_shift = {r_chunk_rem[23:0], i_data_byte};

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_chunk_rem  = r_chunk_rem;
        n_vlq_val    = r_vlq_val;
        n_vlq_cnt    = r_vlq_cnt;
        n_tick       = r_tick;
        n_running    = r_running;
        n_cur_status = r_cur_status;
        n_meta_kind  = r_meta_kind;
        n_pay_rem    = r_pay_rem;
        n_first_data = r_first_data;
        n_tempo      = r_tempo;
        n_err        = r_err;
        take_data    = 1'b0;
        data_status  = r_cur_status;
        evt          = 1'b0;
        evt_kind     = KIND_NOTE_ON;
        evt_note     = 8'd0;
        evt_vel      = 8'd0;
        evt_tempo    = 24'd0;
        trk_end      = 1'b0;
        fail         = 1'b0;
        fail_code    = ERR_BAD_MAGIC;

        if (step) begin
            case (r_phase)
                PH_MAGIC: begin
                    if (i_data_byte != MTRK_MAGIC[{~r_hdr_cnt, 3'b000} +: 8]) begin
                        fail      = 1'b1;
                        fail_code = ERR_BAD_MAGIC;
                    end else if (r_hdr_cnt == 2'd3) begin
                        n_hdr_cnt   = 2'd0;
                        n_chunk_rem = 32'd0;
                        n_phase     = PH_LEN;
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end
                end
                PH_LEN: begin
                    n_chunk_rem = rem_shift;
                    if (r_hdr_cnt == 2'd3) begin
                        n_hdr_cnt = 2'd0;
                        n_tick    = 31'd0;
                        n_running = 8'd0;
                        n_phase   = PH_DELTA;
                        n_vlq_val = 28'd0;
                        n_vlq_cnt = 2'd0;
                        if (rem_shift == 32'd0) begin
                            trk_end = 1'b1;
                            n_phase = PH_MAGIC;
                        end
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end
                end
                default: begin
                    n_chunk_rem = rem_dec;
                    case (r_phase)
                        PH_DELTA: begin
                            if (vlq_long) begin
                                fail      = 1'b1;
                                fail_code = ERR_LONG_VLQ;
                            end else if (i_data_byte[7]) begin
                                n_vlq_val = vlq_next;
                                n_vlq_cnt = r_vlq_cnt + 2'd1;
                            end else begin
                                n_tick    = tick_sum[31] ? TICK_MAX : tick_sum[30:0];
                                n_vlq_val = 28'd0;
                                n_vlq_cnt = 2'd0;
                                n_phase   = PH_STATUS;
                            end
                        end
                        PH_STATUS: begin
                            if (i_data_byte[7]) begin
                                if (i_data_byte == STAT_META) begin
                                    n_phase = PH_META_TYPE;
                                end else if (i_data_byte == STAT_SYSEX ||
                                             i_data_byte == STAT_SYSEX_ESC) begin
                                    n_phase   = PH_SYX_LEN;
                                    n_vlq_val = 28'd0;
                                    n_vlq_cnt = 2'd0;
                                end else if (i_data_byte[7:4] <= HI_PITCH_BEND) begin
                                    n_running    = i_data_byte;
                                    n_cur_status = i_data_byte;
                                    n_phase      = PH_DATA1;
                                end else begin
                                    fail      = 1'b1;
                                    fail_code = ERR_BAD_STATUS;
                                end
                            end else if (r_running == 8'd0) begin
                                fail      = 1'b1;
                                fail_code = ERR_NO_RUNNING;
                            end else begin
                                n_cur_status = r_running;
                                take_data    = 1'b1;
                                data_status  = r_running;
                            end
                        end
                        PH_DATA1: begin
                            take_data = 1'b1;
                        end
                        PH_DATA2: begin
                            if (r_cur_status[7:4] == HI_NOTE_ON && i_data_byte != 8'd0) begin
                                evt      = 1'b1;
                                evt_kind = KIND_NOTE_ON;
                                evt_note = r_first_data;
                                evt_vel  = i_data_byte;
                            end else if (r_cur_status[7:4] == HI_NOTE_ON ||
                                         r_cur_status[7:4] == HI_NOTE_OFF) begin
                                evt      = 1'b1;
                                evt_kind = KIND_NOTE_OFF;
                                evt_note = r_first_data;
                            end
                            n_phase   = PH_DELTA;
                            n_vlq_val = 28'd0;
                            n_vlq_cnt = 2'd0;
                        end
                        PH_META_TYPE: begin
                            n_meta_kind = i_data_byte;
                            n_phase     = PH_META_LEN;
                            n_vlq_val   = 28'd0;
                            n_vlq_cnt   = 2'd0;
                        end
                        PH_META_LEN, PH_SYX_LEN: begin
                            if (vlq_long) begin
                                fail      = 1'b1;
                                fail_code = ERR_LONG_VLQ;
                            end else if (i_data_byte[7]) begin
                                n_vlq_val = vlq_next;
                                n_vlq_cnt = r_vlq_cnt + 2'd1;
                            end else begin
                                n_vlq_val = 28'd0;
                                n_vlq_cnt = 2'd0;
                                if ({4'b0, vlq_next} > rem_dec) begin
                                    fail      = 1'b1;
                                    fail_code = ERR_TRUNCATED;
                                end else if (r_phase == PH_META_LEN &&
                                             r_meta_kind == META_EOT) begin
                                    n_phase = PH_SKIP_END;
                                end else begin
                                    if (r_phase == PH_SYX_LEN ||
                                        !(r_meta_kind == META_TEMPO && vlq_next == 28'd3)) begin
                                        n_meta_kind = 8'd0;
                                    end
                                    n_tempo = 24'd0;
                                    if (vlq_next == 28'd0) begin
                                        n_phase = PH_DELTA;
                                    end else begin
                                        n_pay_rem = vlq_next;
                                        n_phase   = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            if (r_meta_kind == META_TEMPO) begin
                                n_tempo = {r_tempo[15:0], i_data_byte};
                            end
                            n_pay_rem = pay_dec;
                            if (pay_dec == 28'd0) begin
                                if (r_meta_kind == META_TEMPO) begin
                                    evt       = 1'b1;
                                    evt_kind  = KIND_TEMPO;
                                    evt_tempo = (n_tempo == 24'd0) ? DEFAULT_TEMPO : n_tempo;
                                end
                                n_phase   = PH_DELTA;
                                n_vlq_val = 28'd0;
                                n_vlq_cnt = 2'd0;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (take_data) begin
                        n_first_data = i_data_byte;
                        if (data_status[7:4] == HI_PROG_CHANGE ||
                            data_status[7:4] == HI_CHAN_PRESS) begin
                            n_phase   = PH_DELTA;
                            n_vlq_val = 28'd0;
                            n_vlq_cnt = 2'd0;
                        end else begin
                            n_phase = PH_DATA2;
                        end
                    end

                    // last byte of the chunk: must sit between events
                    if (!fail && rem_dec == 32'd0) begin
                        if (n_phase == PH_SKIP_END ||
                            (n_phase == PH_DELTA && n_vlq_cnt == 2'd0)) begin
                            trk_end   = 1'b1;
                            n_phase   = PH_MAGIC;
                            n_hdr_cnt = 2'd0;
                        end else begin
                            fail      = 1'b1;
                            fail_code = ERR_TRUNCATED;
                        end
                    end
                end
            endcase

            if (fail) begin
                n_err = 1'b1;
            end
        end
    end

    // result assembly: event first, then track end
    always_comb begin
        t_result evt_res;
        t_result end_res;
        t_result fail_res;

        evt_res     = '{kind: evt_kind, abs_tick: n_tick, note_number: evt_note,
                        velocity: evt_vel, tempo_us: evt_tempo,
                        error_code: ERR_BAD_MAGIC, last_of_run: 1'b0};
        end_res     = '{kind: KIND_TRACK_END, abs_tick: n_tick, note_number: 8'd0,
                        velocity: 8'd0, tempo_us: 24'd0,
                        error_code: ERR_BAD_MAGIC, last_of_run: 1'b1};
        fail_res    = '{kind: KIND_ERROR, abs_tick: n_tick, note_number: 8'd0,
                        velocity: 8'd0, tempo_us: 24'd0,
                        error_code: fail_code, last_of_run: 1'b1};

        o_dec.num  = 2'd0;
        o_dec.res0 = fail_res;
        o_dec.res1 = end_res;
        if (fail) begin
            o_dec.num  = 2'd1;
            o_dec.res0 = fail_res;
        end else if (evt) begin
            o_dec.res0             = evt_res;
            o_dec.res0.last_of_run = !trk_end;
            o_dec.num              = trk_end ? 2'd2 : 2'd1;
        end else if (trk_end) begin
            o_dec.num  = 2'd1;
            o_dec.res0 = end_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC;
            r_hdr_cnt    <= 2'd0;
            r_chunk_rem  <= 32'd0;
            r_vlq_val    <= 28'd0;
            r_vlq_cnt    <= 2'd0;
            r_tick       <= 31'd0;
            r_running    <= 8'd0;
            r_cur_status <= 8'd0;
            r_meta_kind  <= 8'd0;
            r_pay_rem    <= 28'd0;
            r_first_data <= 8'd0;
            r_tempo      <= 24'd0;
            r_err        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_chunk_rem  <= n_chunk_rem;
            r_vlq_val    <= n_vlq_val;
            r_vlq_cnt    <= n_vlq_cnt;
            r_tick       <= n_tick;
            r_running    <= n_running;
            r_cur_status <= n_cur_status;
            r_meta_kind  <= n_meta_kind;
            r_pay_rem    <= n_pay_rem;
            r_first_data <= n_first_data;
            r_tempo      <= n_tempo;
            r_err        <= n_err;
        end
    end

    a_no_result_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (o_dec.num == 2'd0))
        else $error("decoder produced a result after an error");

    a_pair_is_event_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dec.num == 2'd2) |-> (o_dec.res1.kind == KIND_TRACK_END &&
                                 o_dec.res0.kind != KIND_ERROR &&
                                 o_dec.res0.kind != KIND_TRACK_END))
        else $error("two results per beat must be an event and a track end");

    a_payload_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pay_rem != 28'd0))
        else $error("payload phase with no bytes left");

endmodule

@@ bench/smf_track_sb_pkg.sv @@
`timescale 1ns / 1ps

package smf_track_sb_pkg;
    import smf_pkg::*;

    typedef enum int {
        VLQ_MORE,
        VLQ_END,
        VLQ_OVER
    } t_vlq_step;

    class smf_track_scoreboard;
        t_phase      ph;
        logic [2:0]  hdr_cnt;
        logic [31:0] chunk_left;
        logic [27:0] vlq_acc;
        logic [2:0]  vlq_n;
        logic [30:0] tick;
        logic [7:0]  run_stat;
        logic [7:0]  cur_stat;
        logic [7:0]  meta_type;
        logic [27:0] pay_left;
        logic [7:0]  data1;
        logic [23:0] tempo_acc;
        bit          halted;
        t_result     expected_q[$];
        int          fails;

        function new();
            ph = PH_MAGIC;
            hdr_cnt = '0;
            chunk_left = '0;
            vlq_acc = '0;
            vlq_n = '0;
            tick = '0;
            run_stat = '0;
            cur_stat = '0;
            meta_type = '0;
            pay_left = '0;
            data1 = '0;
            tempo_acc = '0;
            halted = 1'b0;
            fails = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // error code reads zero on every kind but error
        function void push_result(t_kind k, logic [7:0] nn, logic [7:0] vel,
                                  logic [23:0] tp, t_err_code ec);
            t_result r;
            r.kind = k;
            r.abs_tick = tick;
            r.note_number = nn;
            r.velocity = vel;
            r.tempo_us = tp;
            r.error_code = ec;
            r.last_of_run = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void flag_error(t_err_code ec);
            push_result(KIND_ERROR, 8'h00, 8'h00, 24'h0, ec);
            halted = 1'b1;
        endfunction

        function t_vlq_step vlq_step(logic [7:0] b);
            vlq_acc = {vlq_acc[20:0], b[6:0]};
            vlq_n = vlq_n + 3'd1;
            if (b[7]) begin
                if (vlq_n >= 3'd4) return VLQ_OVER;
                return VLQ_MORE;
            end
            vlq_n = 3'd0;
            return VLQ_END;
        endfunction

        function void restart_delta();
            ph = PH_DELTA;
            vlq_acc = '0;
            vlq_n = '0;
        endfunction

        function void take_data(logic [7:0] b);
            data1 = b;
            if (cur_stat[7:4] == HI_PROG_CHANGE || cur_stat[7:4] == HI_CHAN_PRESS) begin
                restart_delta();
            end else begin
                ph = PH_DATA2;
            end
        endfunction

        function void chunk_step(logic [7:0] b);
            t_vlq_step   st;
            logic [31:0] sum;
            logic [27:0] len;
            case (ph)
                PH_DELTA: begin
                    st = vlq_step(b);
                    if (st == VLQ_OVER) begin
                        flag_error(ERR_LONG_VLQ);
                    end else if (st == VLQ_END) begin
                        sum = {1'b0, tick} + {4'h0, vlq_acc};
                        tick = (sum > {1'b0, TICK_MAX}) ? TICK_MAX : sum[30:0];
                        vlq_acc = '0;
                        ph = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!b[7]) begin
                        if (run_stat == 8'h00) begin
                            flag_error(ERR_NO_RUNNING);
                        end else begin
                            cur_stat = run_stat;
                            take_data(b);
                        end
                    end else if (b == STAT_META) begin
                        ph = PH_META_TYPE;
                    end else if (b == STAT_SYSEX || b == STAT_SYSEX_ESC) begin
                        ph = PH_SYX_LEN;
                        vlq_acc = '0;
                        vlq_n = '0;
                    end else if (b[7:4] != 4'hF) begin
                        run_stat = b;
                        cur_stat = b;
                        ph = PH_DATA1;
                    end else begin
                        flag_error(ERR_BAD_STATUS);
                    end
                end
                PH_DATA1: take_data(b);
                PH_DATA2: begin
                    if (cur_stat[7:4] == HI_NOTE_ON && b != 8'h00) begin
                        push_result(KIND_NOTE_ON, data1, b, 24'h0, ERR_BAD_MAGIC);
                    end else if (cur_stat[7:4] == HI_NOTE_ON || cur_stat[7:4] == HI_NOTE_OFF) begin
                        push_result(KIND_NOTE_OFF, data1, 8'h00, 24'h0, ERR_BAD_MAGIC);
                    end
                    restart_delta();
                end
                PH_META_TYPE: begin
                    meta_type = b;
                    ph = PH_META_LEN;
                    vlq_acc = '0;
                    vlq_n = '0;
                end
                PH_META_LEN, PH_SYX_LEN: begin
                    st = vlq_step(b);
                    if (st == VLQ_OVER) begin
                        flag_error(ERR_LONG_VLQ);
                    end else if (st == VLQ_END) begin
                        len = vlq_acc;
                        vlq_acc = '0;
                        if ({4'h0, len} > chunk_left) begin
                            flag_error(ERR_TRUNCATED);
                        end else if (ph == PH_META_LEN && meta_type == META_EOT) begin
                            ph = PH_SKIP_END;
                        end else begin
                            // only a 3-byte tempo meta keeps its type for the payload
                            if (ph == PH_SYX_LEN || meta_type != META_TEMPO || len != 28'd3)
                                meta_type = 8'h00;
                            tempo_acc = '0;
                            if (len == 28'd0) begin
                                restart_delta();
                            end else begin
                                pay_left = len;
                                ph = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (meta_type == META_TEMPO) tempo_acc = {tempo_acc[15:0], b};
                    pay_left = pay_left - 28'd1;
                    if (pay_left == 28'd0) begin
                        if (meta_type == META_TEMPO) begin
                            push_result(KIND_TEMPO, 8'h00, 8'h00,
                                        (tempo_acc == 24'h0) ? DEFAULT_TEMPO : tempo_acc,
                                        ERR_BAD_MAGIC);
                        end
                        restart_delta();
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] magic_b;
            int         first;
            t_result    r;
            first = expected_q.size();
            if (halted) return;
            if (ph == PH_MAGIC) begin
                magic_b = 8'(MTRK_MAGIC >> (8 * (3 - int'(hdr_cnt[1:0]))));
                if (b != magic_b) begin
                    flag_error(ERR_BAD_MAGIC);
                end else begin
                    hdr_cnt = hdr_cnt + 3'd1;
                    if (hdr_cnt >= 3'd4) begin
                        hdr_cnt = '0;
                        chunk_left = '0;
                        ph = PH_LEN;
                    end
                end
            end else if (ph == PH_LEN) begin
                chunk_left = {chunk_left[23:0], b};
                hdr_cnt = hdr_cnt + 3'd1;
                if (hdr_cnt >= 3'd4) begin
                    hdr_cnt = '0;
                    tick = '0;
                    run_stat = '0;
                    restart_delta();
                    if (chunk_left == 32'd0) begin
                        push_result(KIND_TRACK_END, 8'h00, 8'h00, 24'h0, ERR_BAD_MAGIC);
                        ph = PH_MAGIC;
                    end
                end
            end else begin
                chunk_left = chunk_left - 32'd1;
                chunk_step(b);
                if (!halted && chunk_left == 32'd0) begin
                    if (ph == PH_SKIP_END || (ph == PH_DELTA && vlq_n == 3'd0)) begin
                        push_result(KIND_TRACK_END, 8'h00, 8'h00, 24'h0, ERR_BAD_MAGIC);
                        ph = PH_MAGIC;
                        hdr_cnt = '0;
                    end else begin
                        flag_error(ERR_TRUNCATED);
                    end
                end
            end
            if (expected_q.size() > first) begin
                r = expected_q.pop_back();
                r.last_of_run = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function string show(t_result r);
            return $sformatf("kind=%0d tick=%0d note=%02h vel=%02h tempo=%0d code=%0d last=%0b",
                             r.kind, r.abs_tick, r.note_number, r.velocity, r.tempo_us,
                             r.error_code, r.last_of_run);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.abs_tick !== want.abs_tick ||
                got.note_number !== want.note_number || got.velocity !== want.velocity ||
                got.tempo_us !== want.tempo_us || got.error_code !== want.error_code ||
                got.last_of_run !== want.last_of_run) begin
                fails++;
                if (fails <= 10) begin
                    $display("result mismatch at %0t", $time);
                    $display("  exp %s", show(want));
                    $display("  got %s", show(got));
                end
            end
        endfunction
    endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import smf_pkg::*;
    import smf_track_sb_pkg::*;

    localparam int RUN_BYTES    = 1700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_LEN    = 120;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
    localparam logic [3:0] HI_CTRL_CHANGE = 4'hB;
    localparam logic [7:0] NOTE_ON_CH0    = {HI_NOTE_ON, 4'h0};
    localparam logic [7:0] NOTE_OFF_CH0   = {HI_NOTE_OFF, 4'h0};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [30:0] o_abs_tick;
    logic [7:0]  o_note_number;
    logic [7:0]  o_velocity;
    logic [23:0] o_tempo_us;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    smf_track_scoreboard sb;
    logic [7:0]  body_q[$];
    logic [3:0]  run_hi;
    bit          have_run;
    int          beats_sent = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int unsigned cycle_cnt = 0;

    smf_track_event_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_abs_tick    (o_abs_tick),
        .o_note_number (o_note_number),
        .o_velocity    (o_velocity),
        .o_tempo_us    (o_tempo_us),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            seen.kind = t_kind'(o_kind);
            seen.abs_tick = o_abs_tick;
            seen.note_number = o_note_number;
            seen.velocity = o_velocity;
            seen.tempo_us = o_tempo_us;
            seen.error_code = t_err_code'(o_error_code);
            seen.last_of_run = o_last_of_run;
            sb.check_result(seen);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (beats_sent % PHASE_LEN == 0) begin
            case ((beats_sent / PHASE_LEN) % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 82;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 82;
                end
                default: begin
                    idle_pct = 12;
                    stall_pct = 12;
                end
            endcase
        end
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_byte(b);
        beats_sent++;
    endtask

    task automatic send_chunk(input logic [31:0] declared);
        for (int k = 3; k >= 0; k--) send_byte(MTRK_MAGIC[8*k +: 8]);
        for (int k = 3; k >= 0; k--) send_byte(declared[8*k +: 8]);
        foreach (body_q[k]) send_byte(body_q[k]);
    endtask

    // min_len above the natural size pads with redundant 0x80 groups
    task automatic push_vlq(input logic [27:0] v, input int min_len);
        logic [27:0] rest;
        logic [7:0]  enc[$];
        rest = v;
        enc.push_front({1'b0, rest[6:0]});
        rest = rest >> 7;
        while (rest != 0 || enc.size() < min_len) begin
            enc.push_front({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        foreach (enc[i]) body_q.push_back(enc[i]);
    endtask

    task automatic push_delta(input bit huge);
        int pick;
        pick = $urandom_range(9);
        if (huge) begin
            push_vlq(28'($urandom_range(32'h0FFF_FFFF, 32'h0F00_0000)), 4);
        end else if (pick < 6) begin
            push_vlq(28'($urandom_range(127)), 1);
        end else if (pick < 8) begin
            push_vlq(28'($urandom_range(16383, 128)), 1);
        end else if (pick < 9) begin
            push_vlq(28'($urandom), 1);
        end else begin
            push_vlq(28'($urandom_range(40)), $urandom_range(4, 2));
        end
    endtask

    task automatic push_channel();
        logic [3:0] hi;
        if (have_run && $urandom_range(99) < 40) begin
            hi = run_hi;
            // first byte under running status must not look like a status
            body_q.push_back(8'($urandom_range(127)));
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3: hi = HI_NOTE_ON;
                4, 5: hi = HI_NOTE_OFF;
                6: hi = HI_POLY_PRESS;
                7: hi = HI_CTRL_CHANGE;
                8: hi = ($urandom_range(1) != 0) ? HI_PROG_CHANGE : HI_CHAN_PRESS;
                default: hi = HI_PITCH_BEND;
            endcase
            run_hi = hi;
            have_run = 1'b1;
            body_q.push_back({hi, 4'($urandom_range(15))});
            body_q.push_back(8'($urandom));
        end
        if (hi != HI_PROG_CHANGE && hi != HI_CHAN_PRESS)
            body_q.push_back(($urandom_range(99) < 20) ? 8'h00 : 8'($urandom));
    endtask

    task automatic push_set_tempo();
        body_q.push_back(STAT_META);
        body_q.push_back(META_TEMPO);
        push_vlq(28'd3, ($urandom_range(9) == 0) ? 2 : 1);
        if ($urandom_range(4) == 0) begin
            repeat (3) body_q.push_back(8'h00);
        end else begin
            repeat (3) body_q.push_back(8'($urandom));
        end
    endtask

    task automatic push_skipped(input bit sysex);
        int         len;
        logic [7:0] mtype;
        len = ($urandom_range(99) < 5) ? $urandom_range(140, 128) : $urandom_range(12);
        if (sysex) begin
            body_q.push_back(($urandom_range(1) != 0) ? STAT_SYSEX : STAT_SYSEX_ESC);
        end else begin
            if ($urandom_range(4) == 0) begin
                mtype = META_TEMPO;
            end else begin
                do mtype = 8'($urandom); while (mtype == META_EOT);
            end
            body_q.push_back(STAT_META);
            body_q.push_back(mtype);
        end
        push_vlq(28'(len), ($urandom_range(9) == 0) ? 4 : 1);
        repeat (len) body_q.push_back(8'($urandom));
    endtask

    task automatic push_end_of_track();
        int len;
        len = $urandom_range(3);
        body_q.push_back(STAT_META);
        body_q.push_back(META_EOT);
        push_vlq(28'(len), 1);
        repeat (len + $urandom_range(5)) body_q.push_back(8'($urandom));
    endtask

    task automatic build_chunk(input bit huge);
        int n_ev;
        int pick;
        body_q.delete();
        have_run = 1'b0;
        if (huge) n_ev = 12;
        else if ($urandom_range(99) < 6) n_ev = 0;
        else n_ev = $urandom_range(24, 1);
        for (int i = 0; i < n_ev; i++) begin
            push_delta(huge);
            pick = $urandom_range(99);
            if (pick < 60) begin
                push_channel();
            end else if (pick < 72) begin
                push_set_tempo();
            end else if (pick < 84) begin
                push_skipped(1'b0);
            end else if (pick < 95) begin
                push_skipped(1'b1);
            end else begin
                push_end_of_track();
                break;
            end
        end
    endtask

    // error is sticky until reset, so exactly one error case closes the run
    task automatic send_error_tail();
        int         pos;
        logic [7:0] b;
        body_q.delete();
        case ($urandom_range(6))
            0: begin
                pos = $urandom_range(3);
                for (int k = 0; k < pos; k++) send_byte(MTRK_MAGIC[8*(3-k) +: 8]);
                send_byte(MTRK_MAGIC[8*(3-pos) +: 8] ^ 8'($urandom_range(255, 1)));
            end
            1: begin
                // chunk ends inside a note message
                body_q = {8'h00, NOTE_ON_CH0, 8'h3C, 8'h40};
                send_chunk(32'($urandom_range(3, 1)));
            end
            2: begin
                // meta length larger than what is left of the chunk
                body_q = {8'h00, STAT_META, 8'h01, 8'h0A, 8'h41, 8'h42};
                send_chunk(32'($urandom_range(13, 4)));
            end
            3: begin
                body_q = {8'h80, 8'h80, 8'h80, 8'h80};
                send_chunk(32'd16);
            end
            4: begin
                body_q = {8'h00, STAT_META, 8'h01, 8'h80, 8'h80, 8'h80, 8'h80};
                send_chunk(32'd40);
            end
            5: begin
                body_q = {8'h00, 8'($urandom_range(127))};
                send_chunk(32'd8);
            end
            default: begin
                do b = 8'($urandom_range(8'hFE, 8'hF1)); while (b == STAT_SYSEX_ESC);
                body_q = {8'h00, b};
                send_chunk(32'd8);
            end
        endcase
        repeat (10) send_byte(8'($urandom));
    endtask

    initial begin
        int chunk_no;
        sb = new();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // note on, running-status note on with zero velocity, zero tempo,
        // then a note off whose last beat also closes the chunk
        body_q = {8'h00, NOTE_ON_CH0, 8'h3C, 8'h40,
                  8'h00, 8'h3C, 8'h00,
                  8'h00, STAT_META, META_TEMPO, 8'h03, 8'h00, 8'h00, 8'h00,
                  8'h7F, NOTE_OFF_CH0, 8'hFF, 8'h7F};
        send_chunk(32'(body_q.size()));

        chunk_no = 0;
        while (beats_sent < RUN_BYTES) begin
            build_chunk(chunk_no == 1 || $urandom_range(99) < 4);
            send_chunk(32'(body_q.size()));
            chunk_no++;
        end
        send_error_tail();
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ smf_track_event_parser.f @@
rtl/smf_pkg.sv
rtl/smf_decode.sv
rtl/smf_track_event_parser.sv
bench/smf_track_sb_pkg.sv
bench/tb_top.sv
